FILE: sv/blca_pkg.sv
// package: shared constants and sequencer state type for the lca engine
`timescale 1ns / 1ps
`default_nettype none

package blca_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int LOG_LEVELS = 10;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LVL_W      = $clog2(LOG_LEVELS);
  localparam int TAB_DEPTH  = MAX_NODES * LOG_LEVELS;
  localparam int TAB_AW     = $clog2(TAB_DEPTH);
  localparam int DEPTH_XW   = NODE_W + 1;

  // item kinds carried on tuser
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_B0_RD,
    ST_B0_WR,
    ST_BJ_RD1,
    ST_BJ_RD2,
    ST_BJ_WR,
    ST_Q_DP,
    ST_Q_DQ,
    ST_Q_SWAP,
    ST_Q_LIFT,
    ST_Q_LIFT_ANC,
    ST_Q_LIFT_DEP,
    ST_Q_CMP,
    ST_Q_CLIMB,
    ST_Q_CLIMB_Q,
    ST_Q_CLIMB_UPD,
    ST_Q_PAR,
    ST_Q_PAR_WAIT,
    ST_Q_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/binary_lifting_lca_engine_unit.sv
// top level: binary lifting lowest common ancestor engine with its stores and sequencer
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: node_a, node_b, node_depth; tuser: kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: ancestor
// cfg       in   cfg_we (no wait)               cfg_wdata: node_count
//
// timing: query and build work is set by the single read port of the ancestor table,
//   which the sequencer walks one entry per step, lifting and then climbing over up
//   to ten levels; a query whose node is 0 or beyond node_count skips the walk and
//   goes straight to its result
// reset: rst clears the sequencer, node_count and the output valid; the stores are
//   left as they are and hold nothing meaningful until loaded or built
// stalls: s_axis_tready is high only while the sequencer is idle; a finished query
//   waits in the output register, so new items are taken while it is pending, and
//   only a second query result waits for that register to drain

module binary_lifting_lca_engine_unit
  import blca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // config register
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_wdata,     // node_count
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // node_a [9:0], node_b [19:10], node_depth [29:20]
  input  wire logic [1:0]  s_axis_tuser,  // kind [1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // ancestor [9:0]
);

  state_t state, state_next;

  logic [NODE_W-1:0] node_count;

  // working registers
  logic [NODE_W-1:0] p, p_next;        // first node / mid node during build
  logic [NODE_W-1:0] q, q_next;
  logic [NODE_W-1:0] dp, dp_next;
  logic [NODE_W-1:0] dq, dq_next;
  logic [NODE_W-1:0] ap, ap_next;
  logic [NODE_W-1:0] idx, idx_next;    // node index during build
  logic [NODE_W-1:0] res, res_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [LVL_W-1:0]  top, top_next;

  // output register
  logic              out_valid, out_valid_next;
  logic [NODE_W-1:0] out_data, out_data_next;

  // stores
  logic [NODE_W-1:0] par_mem [MAX_NODES];
  logic [NODE_W-1:0] dep_mem [MAX_NODES];
  logic [NODE_W-1:0] tab_mem [TAB_DEPTH];

  logic              ld_we;
  logic [NODE_W-1:0] par_raddr, dep_raddr;
  logic [NODE_W-1:0] par_rd, dep_rd;
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  logic [NODE_W-1:0] tab_wdata, tab_rd;

  // unpacked input payload
  logic [NODE_W-1:0] in_a, in_b, in_d;
  logic              in_fire;

  assign in_a    = s_axis_tdata[9:0];
  assign in_b    = s_axis_tdata[19:10];
  assign in_d    = s_axis_tdata[29:20];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(16 - NODE_W){1'b0}}, out_data};

  // shared decisions
  logic              q_bad;
  logic              lvl_last;
  logic              idx_last;
  logic              lift_ok;
  logic              swap;
  logic [NODE_W-1:0] deeper;
  logic [NODE_W-1:0] aq_eff;
  logic              climb_take;
  logic              out_free;

  // floor(log2(d)) capped at the top level, 0 for d below 2
  function automatic logic [LVL_W-1:0] top_level(input logic [NODE_W-1:0] d);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int k = 1; k < NODE_W; k++) begin
      if (d[k]) begin
        r = (k > LOG_LEVELS - 1) ? LVL_W'(LOG_LEVELS - 1) : LVL_W'(k);
      end
    end
    return r;
  endfunction

  assign q_bad      = (in_a == '0) || (in_b == '0) || (in_a > node_count) ||
                      (in_b > node_count);
  assign lvl_last   = (lvl == '0);
  assign idx_last   = (idx == node_count);
  // depth(p) - 2^lvl >= depth(q), kept unsigned one bit wider
  assign lift_ok    = ({1'b0, dp} >= ({1'b0, dq} + (DEPTH_XW'(1) << lvl)));
  assign swap       = (dp < dep_rd);
  assign deeper     = swap ? dep_rd : dp;
  assign aq_eff     = (q == '0) ? '0 : tab_rd;
  assign climb_take = (ap != '0) && (ap != aq_eff);
  assign out_free   = !out_valid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            KIND_BUILD: if (node_count != '0) state_next = ST_B0_RD;
            KIND_QUERY: state_next = q_bad ? ST_Q_DONE : ST_Q_DP;
            default: ;
          endcase
        end
      end
      ST_B0_RD:  state_next = ST_B0_WR;
      ST_B0_WR:  state_next = idx_last ? ST_BJ_RD1 : ST_B0_RD;
      ST_BJ_RD1: state_next = ST_BJ_RD2;
      ST_BJ_RD2: state_next = ST_BJ_WR;
      ST_BJ_WR: begin
        if (idx_last && (lvl == LVL_W'(LOG_LEVELS - 1))) state_next = ST_IDLE;
        else state_next = ST_BJ_RD1;
      end
      ST_Q_DP:   state_next = ST_Q_DQ;
      ST_Q_DQ:   state_next = ST_Q_SWAP;
      ST_Q_SWAP: state_next = ST_Q_LIFT;
      ST_Q_LIFT: begin
        if (lift_ok) state_next = ST_Q_LIFT_ANC;
        else if (lvl_last) state_next = ST_Q_CMP;
      end
      ST_Q_LIFT_ANC: begin
        if (tab_rd != '0) state_next = ST_Q_LIFT_DEP;
        else state_next = lvl_last ? ST_Q_CMP : ST_Q_LIFT;
      end
      ST_Q_LIFT_DEP: state_next = lvl_last ? ST_Q_CMP : ST_Q_LIFT;
      ST_Q_CMP: begin
        if ((p == q) || (p == '0)) state_next = ST_Q_DONE;
        else state_next = ST_Q_CLIMB;
      end
      ST_Q_CLIMB:     state_next = ST_Q_CLIMB_Q;
      ST_Q_CLIMB_Q:   state_next = ST_Q_CLIMB_UPD;
      ST_Q_CLIMB_UPD: state_next = lvl_last ? ST_Q_PAR : ST_Q_CLIMB;
      ST_Q_PAR:       state_next = ST_Q_PAR_WAIT;
      ST_Q_PAR_WAIT:  state_next = ST_Q_DONE;
      ST_Q_DONE:      if (out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    p_next         = p;
    q_next         = q;
    dp_next        = dp;
    dq_next        = dq;
    ap_next        = ap;
    idx_next       = idx;
    res_next       = res;
    lvl_next       = lvl;
    top_next       = top;
    out_data_next  = out_data;
    out_valid_next = out_valid && !m_axis_tready;
    ld_we          = 1'b0;
    par_raddr      = idx;
    dep_raddr      = p;
    tab_we         = 1'b0;
    tab_waddr      = TAB_AW'({lvl, idx});
    tab_wdata      = '0;
    tab_raddr      = TAB_AW'({lvl, p});

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            KIND_LOAD: ld_we = (in_a != '0);
            KIND_BUILD: begin
              idx_next = NODE_W'(1);
              lvl_next = '0;
            end
            KIND_QUERY: begin
              p_next   = in_a;
              q_next   = in_b;
              res_next = '0;
            end
            default: ;
          endcase
        end
      end

      // level 0: clip parents outside the node range
      ST_B0_RD: par_raddr = idx;
      ST_B0_WR: begin
        tab_we    = 1'b1;
        tab_waddr = TAB_AW'({lvl, idx});
        tab_wdata = (par_rd > node_count) ? '0 : par_rd;
        if (idx_last) begin
          idx_next = NODE_W'(1);
          lvl_next = LVL_W'(1);
        end else begin
          idx_next = idx + NODE_W'(1);
        end
      end

      // level j: ancestor of the level j-1 ancestor
      ST_BJ_RD1: tab_raddr = TAB_AW'({lvl - LVL_W'(1), idx});
      ST_BJ_RD2: begin
        p_next    = tab_rd;
        tab_raddr = TAB_AW'({lvl - LVL_W'(1), tab_rd});
      end
      ST_BJ_WR: begin
        tab_we    = 1'b1;
        tab_waddr = TAB_AW'({lvl, idx});
        tab_wdata = (p == '0) ? '0 : tab_rd;
        if (idx_last) begin
          idx_next = NODE_W'(1);
          lvl_next = lvl + LVL_W'(1);
        end else begin
          idx_next = idx + NODE_W'(1);
        end
      end

      ST_Q_DP: dep_raddr = p;
      ST_Q_DQ: begin
        dp_next   = dep_rd;
        dep_raddr = q;
      end
      ST_Q_SWAP: begin
        if (swap) begin
          p_next  = q;
          q_next  = p;
          dp_next = dep_rd;
          dq_next = dp;
        end else begin
          dq_next = dep_rd;
        end
        top_next = top_level(deeper);
        lvl_next = top_level(deeper);
      end

      // lift the deeper node level by level
      ST_Q_LIFT: begin
        tab_raddr = TAB_AW'({lvl, p});
        if (!lift_ok && !lvl_last) lvl_next = lvl - LVL_W'(1);
      end
      ST_Q_LIFT_ANC: begin
        p_next    = tab_rd;
        dep_raddr = tab_rd;
        if (tab_rd == '0) begin
          dp_next = '0;
          if (!lvl_last) lvl_next = lvl - LVL_W'(1);
        end
      end
      ST_Q_LIFT_DEP: begin
        dp_next = dep_rd;
        if (!lvl_last) lvl_next = lvl - LVL_W'(1);
      end

      ST_Q_CMP: begin
        res_next = (p == q) ? p : '0;
        lvl_next = top;
      end

      // climb both while their ancestors differ
      ST_Q_CLIMB: tab_raddr = TAB_AW'({lvl, p});
      ST_Q_CLIMB_Q: begin
        ap_next   = tab_rd;
        tab_raddr = TAB_AW'({lvl, q});
      end
      ST_Q_CLIMB_UPD: begin
        if (climb_take) begin
          p_next = ap;
          q_next = aq_eff;
        end
        if (!lvl_last) lvl_next = lvl - LVL_W'(1);
      end

      ST_Q_PAR:      par_raddr = p;
      ST_Q_PAR_WAIT: res_next = par_rd;

      ST_Q_DONE: begin
        if (out_free) begin
          out_data_next  = res;
          out_valid_next = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_we) node_count <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p        <= p_next;
    q        <= q_next;
    dp       <= dp_next;
    dq       <= dq_next;
    ap       <= ap_next;
    idx      <= idx_next;
    res      <= res_next;
    lvl      <= lvl_next;
    top      <= top_next;
    out_data <= out_data_next;
  end

  // parent and depth stores
  always_ff @(posedge clk) begin
    if (ld_we) begin
      par_mem[in_a] <= in_b;
      dep_mem[in_a] <= in_d;
    end
    par_rd <= par_mem[par_raddr];
    dep_rd <= dep_mem[dep_raddr];
  end

  // ancestor table, entry {level, node}
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rd <= tab_mem[tab_raddr];
  end

endmodule

`default_nettype wire
